FILE: src/dlw_pkg.sv
// Shared types and constants for the display list walker.
package dlw_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int ADDR_BITS_DEF   = 16;
    localparam int FIELD_ADDR_W    = 16;

    typedef enum logic [1:0] {
        OP_ORDINARY = 2'd0,
        OP_CALL     = 2'd1,
        OP_BRANCH   = 2'd2,
        OP_RETURN   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CONTINUE = 3'd0,
        ST_DONE     = 3'd1,
        ST_INVALID  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_IDLE     = 3'd4
    } t_status;

    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] fetch_addr;
        logic                    forward;
        t_status                 status;
    } t_result;

endpackage

FILE: src/dlw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/dlw_seq.sv
// Walk state, return stack control and per-request result logic.
module dlw_seq #(
    parameter int STACK_DEPTH = dlw_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_BITS   = dlw_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_mode,
    input  logic [dlw_pkg::FIELD_ADDR_W-1:0]  i_address,
    input  logic [1:0]                        i_opcode,
    input  logic                              i_predicate,
    output dlw_pkg::t_result                  o_result
);

    localparam int FW = dlw_pkg::FIELD_ADDR_W;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int PW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic                 r_walking, n_walking;
    logic [ADDR_BITS-1:0] r_cur, n_cur;
    logic [DW-1:0]        r_depth, n_depth;
    logic [ADDR_BITS-1:0] r_top, n_top;

    logic [ADDR_BITS+FW-1:0] in_ext;
    logic [ADDR_BITS+FW-1:0] out_ext;
    logic [ADDR_BITS-1:0]    addr;
    logic [ADDR_BITS-1:0]    next_addr;
    logic [ADDR_BITS-1:0]    res_addr;
    logic                    addr_null;
    logic                    push;
    logic [DW-1:0]           rd_sum;
    logic [PW-1:0]           rd_idx;
    logic [ADDR_BITS-1:0]    below_top;
    dlw_pkg::t_opcode        op;
    dlw_pkg::t_status        status;
    logic                    fwd;

    assign in_ext    = {{ADDR_BITS{1'b0}}, i_address};
    assign addr      = in_ext[ADDR_BITS-1:0];
    assign next_addr = r_cur + ADDR_BITS'(1);
    assign addr_null = (addr == '0);
    assign op        = dlw_pkg::t_opcode'(i_opcode);

    always_comb begin
        n_walking = r_walking;
        n_cur     = r_cur;
        n_depth   = r_depth;
        n_top     = r_top;
        push      = 1'b0;
        res_addr  = r_cur;
        fwd       = 1'b0;
        status    = dlw_pkg::ST_CONTINUE;
        if (!i_mode) begin
            n_depth = '0;
            if (addr_null) begin
                n_walking = 1'b0;
                n_cur     = '0;
                res_addr  = '0;
                status    = dlw_pkg::ST_INVALID;
            end else begin
                n_walking = 1'b1;
                n_cur     = addr;
                res_addr  = addr;
            end
        end else if (!r_walking) begin
            status = dlw_pkg::ST_IDLE;
        end else begin
            unique case (op)
                dlw_pkg::OP_CALL: begin
                    if (addr_null) begin
                        n_walking = 1'b0;
                        status    = dlw_pkg::ST_INVALID;
                    end else if (r_depth >= DW'(STACK_DEPTH)) begin
                        n_walking = 1'b0;
                        status    = dlw_pkg::ST_OVERFLOW;
                    end else begin
                        push     = 1'b1;
                        n_depth  = r_depth + DW'(1);
                        n_top    = next_addr;
                        n_cur    = addr;
                        res_addr = addr;
                    end
                end
                dlw_pkg::OP_BRANCH: begin
                    if (addr_null) begin
                        n_walking = 1'b0;
                        status    = dlw_pkg::ST_INVALID;
                    end else begin
                        n_cur    = i_predicate ? addr : next_addr;
                        res_addr = n_cur;
                    end
                end
                dlw_pkg::OP_RETURN: begin
                    if (r_depth == '0) begin
                        n_walking = 1'b0;
                        status    = dlw_pkg::ST_DONE;
                    end else begin
                        // pop: the cached top becomes the address, the entry below it the new top
                        n_depth  = r_depth - DW'(1);
                        n_cur    = r_top;
                        res_addr = r_top;
                        n_top    = below_top;
                    end
                end
                default: begin
                    n_cur    = next_addr;
                    res_addr = next_addr;
                    fwd      = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking <= 1'b0;
            r_cur     <= '0;
            r_depth   <= '0;
        end else if (i_accept) begin
            r_walking <= n_walking;
            r_cur     <= n_cur;
            r_depth   <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_top <= n_top;
        end
    end

    // keep the entry just below the top on the RAM read port for the next request
    assign rd_sum = (i_accept ? n_depth : r_depth) - DW'(2);
    assign rd_idx = rd_sum[PW-1:0];

    dlw_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_accept && push),
        .i_waddr (r_depth[PW-1:0]),
        .i_wdata (next_addr),
        .i_raddr (rd_idx),
        .o_rdata (below_top)
    );

    assign out_ext             = {{FW{1'b0}}, res_addr};
    assign o_result.fetch_addr = out_ext[FW-1:0];
    assign o_result.forward    = fwd;
    assign o_result.status     = status;

endmodule

FILE: src/display_list_walker_core.sv
// Top level of the display list walker: handshakes and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | to core   | i_in_valid / o_in_stall | i_mode i_address i_opcode i_predicate
//  out     | from core | o_out_valid / i_out_stall | o_fetch_addr o_forward o_status
//
// One request per cycle unless the input stalls; each gives one registered result.
// The return stack keeps its top in a register and reads the entry below it from the
// stack RAM in advance, so consecutive returns run at one per cycle unless stalled.
// Synchronous active-low reset clears walk state and the result valid; the stack RAM
// is not cleared. Input stalls only while a result is held and out is stalled.
module display_list_walker_core #(
    parameter int STACK_DEPTH = dlw_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_BITS   = dlw_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [dlw_pkg::FIELD_ADDR_W-1:0]  i_address,
    input  logic [1:0]                        i_opcode,
    input  logic                              i_predicate,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dlw_pkg::FIELD_ADDR_W-1:0]  o_fetch_addr,
    output logic                              o_forward,
    output logic [2:0]                        o_status
);

    logic             accept;
    logic             r_out_valid;
    dlw_pkg::t_result result;
    dlw_pkg::t_result r_result;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    dlw_seq #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_address   (i_address),
        .i_opcode    (i_opcode),
        .i_predicate (i_predicate),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result while out is stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fetch_addr = r_result.fetch_addr;
    assign o_forward    = r_result.forward;
    assign o_status     = r_result.status;

endmodule

FILE: bench/display_list_walker_core_tb.sv
// Self-checking testbench for the display list walker core, with its own walk predictor.
`timescale 1ns / 1ps

module display_list_walker_core_tb;

    localparam int RET_DEPTH   = dlw_pkg::STACK_DEPTH_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_mode      = 1'b0;
    logic [15:0] i_address   = '0;
    logic [1:0]  i_opcode    = '0;
    logic        i_predicate = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_fetch_addr;
    logic        o_forward;
    logic [2:0]  o_status;

    // predictor state
    bit          walk_on    = 1'b0;
    logic [15:0] walk_addr  = '0;
    int          walk_depth = 0;
    logic [15:0] walk_returns [RET_DEPTH];

    dlw_pkg::t_result walk_results_due [$];
    int      requests_sent = 0;
    int      mismatches    = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      hold_request  = 0;
    int      hold_left     = 0;
    int      quiet_cycles  = 0;

    display_list_walker_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_address   (i_address),
        .i_opcode    (i_opcode),
        .i_predicate (i_predicate),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_fetch_addr(o_fetch_addr),
        .o_forward   (o_forward),
        .o_status    (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the predicted walk by one request and return the result it gives.
    function automatic dlw_pkg::t_result step_walk(input bit mode, input logic [15:0] addr,
                                                   input dlw_pkg::t_opcode op,
                                                   input bit pred);
        dlw_pkg::t_result res;
        logic [15:0]      next_addr;
        next_addr   = walk_addr + 16'd1;
        res.forward = 1'b0;
        res.status  = dlw_pkg::ST_CONTINUE;
        if (!mode) begin
            walk_depth = 0;
            if (addr == '0) begin
                walk_on    = 1'b0;
                walk_addr  = '0;
                res.status = dlw_pkg::ST_INVALID;
            end else begin
                walk_on   = 1'b1;
                walk_addr = addr;
            end
        end else if (!walk_on) begin
            res.status = dlw_pkg::ST_IDLE;
        end else begin
            unique case (op)
                dlw_pkg::OP_CALL: begin
                    if (addr == '0) begin
                        walk_on    = 1'b0;
                        res.status = dlw_pkg::ST_INVALID;
                    end else if (walk_depth >= RET_DEPTH) begin
                        walk_on    = 1'b0;
                        res.status = dlw_pkg::ST_OVERFLOW;
                    end else begin
                        walk_returns[walk_depth] = next_addr;
                        walk_depth++;
                        walk_addr = addr;
                    end
                end
                dlw_pkg::OP_BRANCH: begin
                    if (addr == '0) begin
                        walk_on    = 1'b0;
                        res.status = dlw_pkg::ST_INVALID;
                    end else begin
                        walk_addr = pred ? addr : next_addr;
                    end
                end
                dlw_pkg::OP_RETURN: begin
                    if (walk_depth == 0) begin
                        walk_on    = 1'b0;
                        res.status = dlw_pkg::ST_DONE;
                    end else begin
                        walk_depth--;
                        walk_addr = walk_returns[walk_depth];
                    end
                end
                default: begin
                    walk_addr   = next_addr;
                    res.forward = 1'b1;
                end
            endcase
        end
        res.fetch_addr = walk_addr;
        return res;
    endfunction

    // Bias towards null, top and bottom addresses.
    function automatic logic [15:0] random_address();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return 16'h0000;
        else if (pick < 6)
            return 16'hFFFF;
        else if (pick < 9)
            return 16'h0001;
        return 16'($urandom_range(1, 65535));
    endfunction

    task automatic issue_request(input bit mode, input logic [15:0] addr,
                                 input dlw_pkg::t_opcode op, input bit pred);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_address   <= addr;
        i_opcode    <= op;
        i_predicate <= pred;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        walk_results_due.push_back(step_walk(mode, addr, op, pred));
        requests_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (walk_results_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // One start followed by commands, with occasional restarts, until the walk stops or the budget runs out.
    task automatic random_walk(input int max_cmds);
        int               call_w;
        int               ret_w;
        int               pick;
        int               n;
        dlw_pkg::t_opcode op;
        bit               deep;
        deep   = ($urandom_range(0, 3) == 0);
        call_w = deep ? 45 : 20;
        ret_w  = deep ? 10 : 22;
        n      = 0;
        issue_request(1'b0, random_address(), dlw_pkg::t_opcode'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
        while (walk_on && n < max_cmds) begin
            if ($urandom_range(0, 99) < 2) begin
                issue_request(1'b0, random_address(),
                              dlw_pkg::t_opcode'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < call_w)
                    op = dlw_pkg::OP_CALL;
                else if (pick < call_w + ret_w)
                    op = dlw_pkg::OP_RETURN;
                else if (pick < call_w + ret_w + 15)
                    op = dlw_pkg::OP_BRANCH;
                else
                    op = dlw_pkg::OP_ORDINARY;
                issue_request(1'b1, random_address(), op, 1'($urandom_range(0, 1)));
            end
            n++;
        end
        // occasionally a stray command after the loop, which may find no walk running
        if ($urandom_range(0, 4) == 0)
            issue_request(1'b1, random_address(), dlw_pkg::t_opcode'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        issue_request(1'b1, 16'h1234, dlw_pkg::OP_ORDINARY, 1'b0);
        issue_request(1'b0, 16'h0000, dlw_pkg::OP_ORDINARY, 1'b0);
        issue_request(1'b0, 16'hFFFF, dlw_pkg::OP_RETURN,   1'b1);
        issue_request(1'b1, 16'h0000, dlw_pkg::OP_ORDINARY, 1'b1);
        issue_request(1'b1, 16'h1234, dlw_pkg::OP_BRANCH,   1'b0);
        issue_request(1'b1, 16'h8000, dlw_pkg::OP_BRANCH,   1'b1);
        issue_request(1'b1, 16'hFFFF, dlw_pkg::OP_CALL,     1'b0);
        issue_request(1'b1, 16'h0001, dlw_pkg::OP_CALL,     1'b1);
        issue_request(1'b1, 16'hFFFF, dlw_pkg::OP_RETURN,   1'b0);
        issue_request(1'b1, 16'h0000, dlw_pkg::OP_RETURN,   1'b1);
        issue_request(1'b1, 16'h5A5A, dlw_pkg::OP_RETURN,   1'b0);
        issue_request(1'b1, 16'hA5A5, dlw_pkg::OP_RETURN,   1'b1);
        // restart mid-walk drops the stack
        issue_request(1'b0, 16'h0100, dlw_pkg::OP_ORDINARY, 1'b0);
        issue_request(1'b1, 16'h0300, dlw_pkg::OP_CALL,     1'b0);
        issue_request(1'b0, 16'h0200, dlw_pkg::OP_CALL,     1'b0);
        issue_request(1'b1, 16'h0000, dlw_pkg::OP_RETURN,   1'b0);
        // null targets
        issue_request(1'b0, 16'h0001, dlw_pkg::OP_ORDINARY, 1'b0);
        issue_request(1'b1, 16'h0000, dlw_pkg::OP_CALL,     1'b1);
        issue_request(1'b0, 16'h0002, dlw_pkg::OP_ORDINARY, 1'b0);
        issue_request(1'b1, 16'h0000, dlw_pkg::OP_BRANCH,   1'b1);
        // null start while walking
        issue_request(1'b0, 16'h0003, dlw_pkg::OP_ORDINARY, 1'b0);
        issue_request(1'b1, 16'h5555, dlw_pkg::OP_CALL,     1'b0);
        issue_request(1'b0, 16'h0000, dlw_pkg::OP_BRANCH,   1'b0);
        issue_request(1'b1, 16'h7777, dlw_pkg::OP_ORDINARY, 1'b0);
    endtask

    task automatic test_stack_limits();
        issue_request(1'b0, 16'h4000, dlw_pkg::OP_ORDINARY, 1'b0);
        repeat (RET_DEPTH)
            issue_request(1'b1, 16'($urandom_range(1, 65535)), dlw_pkg::OP_CALL, 1'b0);
        repeat (RET_DEPTH + 1)
            issue_request(1'b1, 16'($urandom_range(0, 65535)), dlw_pkg::OP_RETURN, 1'b0);
        issue_request(1'b0, 16'h7000, dlw_pkg::OP_ORDINARY, 1'b0);
        repeat (RET_DEPTH + 1)
            issue_request(1'b1, 16'($urandom_range(1, 65535)), dlw_pkg::OP_CALL, 1'b1);
    endtask

    task automatic test_random_phase(input int n_items, input int send_pct,
                                     input int recv_pct);
        int target;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        target        = requests_sent + n_items;
        while (requests_sent < target)
            random_walk($urandom_range(4, 40));
    endtask

    // Hold the result side off while requests keep coming, then drain fully.
    task automatic test_backpressure();
        int target;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = HOLD_CYCLES;
        target        = requests_sent + 40;
        while (requests_sent < target)
            random_walk(40);
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_stack_limits();
        test_random_phase(370, 0, 0);
        test_random_phase(370, 46, 0);
        test_backpressure();
        test_random_phase(370, 0, 46);
        test_random_phase(370, 9, 9);
        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && walk_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        dlw_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (walk_results_due.size() == 0) begin
                $display("%0t: unexpected result fetch_addr %h forward %b status %0d",
                         $time, o_fetch_addr, o_forward, o_status);
                mismatches++;
            end else begin
                want = walk_results_due.pop_front();
                if (o_fetch_addr !== want.fetch_addr) begin
                    $display("%0t: fetch_addr expected %h, got %h",
                             $time, want.fetch_addr, o_fetch_addr);
                    mismatches++;
                end
                if (o_forward !== want.forward) begin
                    $display("%0t: forward expected %b, got %b",
                             $time, want.forward, o_forward);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

FILE: sim.f
src/dlw_pkg.sv
src/dlw_ram.sv
src/dlw_seq.sv
src/display_list_walker_core.sv
bench/display_list_walker_core_tb.sv
